// ===== design/fis_pkg.sv =====
package fis_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int WORD_BITS_DEF   = 32;
	localparam int WARMUP_BITS     = 20;
	localparam int SENS_BITS       = 32;
	localparam int COEF_FRAC       = 30;
	localparam int COEF_BITS       = 32;
	localparam logic [WARMUP_BITS-1:0] WARMUP_RESET = 20'd600000;

	// Q16.16 scale factor applied to the smoothed square.
	localparam logic [SENS_BITS-1:0] SCALE_Q16 = 32'd2553796475;

	localparam logic signed [COEF_BITS-1:0] MEAN_B0  = 32'sd5369;
	localparam logic signed [COEF_BITS-1:0] MEAN_NA1 = 32'sd1073731086;
	localparam logic signed [COEF_BITS-1:0] HP_B0    = 32'sd1073724958;
	localparam logic signed [COEF_BITS-1:0] HP_NA1   = 32'sd1073708092;
	localparam logic signed [COEF_BITS-1:0] SM_B0    = 32'sd178927;
	localparam logic signed [COEF_BITS-1:0] SM_NA1   = 32'sd1073383970;

	// Biquad coefficients, five per section: b0, b1, b2, -a1, a2 (Q2.30).
	function automatic logic signed [COEF_BITS-1:0] bq_coef(input logic [2:0] sec,
			input logic [2:0] idx);
		logic signed [COEF_BITS-1:0] c;
		c = '0;
		case (sec)
			3'd0: begin
				case (idx)
					3'd0: c = 32'sd127993;
					3'd1: c = 32'sd256761;
					3'd2: c = 32'sd128770;
					3'd3: c = 32'sd2102313824;
					3'd4: c = 32'sd1029080383;
					default: c = '0;
				endcase
			end
			3'd1: begin
				case (idx)
					3'd0: c = 32'sd127993;
					3'd1: c = 32'sd255987;
					3'd2: c = 32'sd127996;
					3'd3: c = 32'sd2114092984;
					3'd4: c = 32'sd1040862438;
					default: c = '0;
				endcase
			end
			3'd2: begin
				case (idx)
					3'd0: c = 32'sd127993;
					3'd1: c = 32'sd255209;
					3'd2: c = 32'sd127218;
					3'd3: c = 32'sd2134815258;
					3'd4: c = 32'sd1061589710;
					default: c = '0;
				endcase
			end
			3'd3: begin
				case (idx)
					3'd0: c = 32'sd377563037;
					3'd1: c = -32'sd718807584;
					3'd2: c = 32'sd341244546;
					3'd3: c = 32'sd2131983357;
					3'd4: c = 32'sd1058252827;
					default: c = '0;
				endcase
			end
			3'd4: begin
				case (idx)
					3'd0: c = 32'sd377563037;
					3'd1: c = -32'sd752722076;
					3'd2: c = 32'sd375161706;
					3'd3: c = 32'sd2141984282;
					3'd4: c = 32'sd1068277895;
					default: c = '0;
				endcase
			end
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

// ===== design/flicker_instant_sensation_top.sv =====
// Instantaneous flicker sensation for a 50 Hz supply. Each transfer on the
// sample channel carries one voltage sample. The block tracks the mean,
// normalizes the sample by it with a radix-2 divider, runs the weighting
// chain (high-pass, three band-limiting biquads, two eye-brain biquads),
// squares, smooths and scales. Samples are taken one at a time: a new
// sample is not taken until the last has been through the mean, the divider
// (one quotient bit a cycle plus a closing step), the high-pass, the five
// biquads, the square, the smoothing and the scaling and, after warm-up,
// until its result has been offered and taken; out_stall holds the result.
// All products go through a single shared multiplier. A sample still in
// warm-up gives no result and goes back to idle after the smoothing. All
// filter taps live in one synchronous memory with a registered read, each
// tap read before the arithmetic that needs it and written back afterwards.
// While the warm-up count runs, no result transfer is made; after it, every
// sample gives one result, sensation in unsigned Q16.16 with saturated
// raised when the value was clipped at full scale. The warm-up register is
// written through its own valid/ready channel, only while idle or during
// the reset pass over the tap memory.
module flicker_instant_sensation_top #(
	parameter int SAMPLE_BITS = fis_pkg::SAMPLE_BITS_DEF,
	parameter int WORD_BITS   = fis_pkg::WORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [SAMPLE_BITS-1:0]              sample,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [fis_pkg::SENS_BITS-1:0]       sensation,
	output logic                                saturated,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [fis_pkg::WARMUP_BITS-1:0]     cfg_data
);
	import fis_pkg::*;

	localparam int W     = WORD_BITS;
	localparam int FRAC  = W - 8;
	localparam int MFRAC = W - SAMPLE_BITS;
	localparam int PW    = 64;
	localparam int AW    = 5;
	localparam int QB    = FRAC + 8;
	localparam int DCW   = $clog2(W + FRAC + 1);
	localparam int MB    = (W > SENS_BITS) ? W + 1 : SENS_BITS + 1;

	// Tap memory layout.
	localparam logic [AW-1:0] A_MX  = 5'd0;
	localparam logic [AW-1:0] A_MY  = 5'd1;
	localparam logic [AW-1:0] A_HX  = 5'd2;
	localparam logic [AW-1:0] A_HY  = 5'd3;
	localparam logic [AW-1:0] A_BQ  = 5'd4;
	localparam logic [AW-1:0] A_SX  = 5'd24;
	localparam logic [AW-1:0] A_SY  = 5'd25;
	localparam logic [AW-1:0] A_END = 5'd26;

	typedef enum logic [10:0] {
		S_INIT  = 11'b00000000001,
		S_IDLE  = 11'b00000000010,
		S_MEAN  = 11'b00000000100,
		S_DIV   = 11'b00000001000,
		S_HP    = 11'b00000010000,
		S_BQ    = 11'b00000100000,
		S_SQ    = 11'b00001000000,
		S_SM    = 11'b00010000000,
		S_SCALE = 11'b00100000000,
		S_OUT   = 11'b01000000000,
		S_WB    = 11'b10000000000
	} state_t;

	state_t state_q;
	logic [AW-1:0] init_q;
	logic [3:0] step_q;
	logic [2:0] sec_q;
	logic [W-1:0] tap_mem [0:A_END-1];
	logic [W-1:0] rd_s1;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [W-1:0] wr_data;
	logic wr_en;
	logic [WARMUP_BITS-1:0] warm_q, seen_q;
	logic [W-1:0] x_q, mean_q, y_q;
	logic signed [PW-1:0] acc_q;
	logic [W-1:0] t0_q, t2_q;
	logic [QB-1:0] quo_q;
	logic [W+1:0] rem_q;
	logic [DCW-1:0] dcnt_q;
	logic sat_q;

	// Shared rounding multiplier: signed times signed (a coefficient or a word
	// times a word), rounded half away from zero at shift sh. Register-to-register.
	logic signed [PW-1:0] mul_a, mul_b;
	logic [6:0] mul_sh;
	logic [PW-1:0] mag_a, mag_b, mag_p, mag_r;
	logic [2*PW-1:0] full_p;
	logic signed [PW-1:0] mul_res;
	logic mul_neg;

	always_comb begin
		mag_a = mul_a[PW-1] ? PW'(-mul_a) : PW'(mul_a);
		mag_b = mul_b[PW-1] ? PW'(-mul_b) : PW'(mul_b);
		full_p = (2*PW)'(mag_a[MB-1:0]) * (2*PW)'(mag_b[MB-1:0]);
		mag_p = PW'((full_p + ((2*PW)'(1) << (mul_sh - 7'd1))) >> mul_sh);
		mag_r = mag_p;
		mul_neg = mul_a[PW-1] ^ mul_b[PW-1];
		mul_res = mul_neg ? -$signed(mag_r) : $signed(mag_r);
	end

	function automatic logic [W-1:0] sat_w(input logic signed [PW-1:0] v);
		logic signed [PW-1:0] hi, lo;
		hi = (PW'(1) <<< (W - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return W'(hi);
		if (v < lo) return W'(lo);
		return W'(v);
	endfunction

	function automatic logic signed [PW-1:0] sx(input logic [W-1:0] v);
		return PW'($signed(v));
	endfunction

	logic in_acc;
	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE) || (state_q == S_INIT);
	assign out_valid = (state_q == S_OUT);

	// Read address for the tap needed next cycle.
	always_comb begin
		rd_addr = A_MX;
		case (state_q)
			S_IDLE: rd_addr = A_MX;
			S_MEAN: rd_addr = (step_q == 4'd0) ? A_MY : A_HX;
			S_DIV:  rd_addr = A_HX;
			S_HP:   rd_addr = A_HY;
			S_BQ:   rd_addr = A_BQ + AW'({sec_q, 2'b00}) + AW'(step_q[1:0]);
			S_SQ:   rd_addr = A_SX;
			S_SM:   rd_addr = A_SY;
			default: rd_addr = A_MX;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			tap_mem[wr_addr] <= wr_data;
		rd_s1 <= tap_mem[rd_addr];
	end

	// Main sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			init_q  <= '0;
			step_q  <= '0;
			sec_q   <= '0;
			warm_q  <= WARMUP_RESET;
			seen_q  <= '0;
			wr_en   <= 1'b0;
		end else begin
			// Tap write-back strobe, one per state step that stores a tap.
			wr_en <= (state_q == S_INIT)
				|| ((state_q == S_MEAN) && (step_q == 4'd0 || step_q >= 4'd3))
				|| ((state_q == S_HP || state_q == S_SM) && step_q != 4'd1)
				|| ((state_q == S_BQ) && step_q >= 4'd5);
			if (cfg_valid && cfg_ready)
				warm_q <= cfg_data;
			case (state_q)
				S_INIT: begin
					// Reset pass over the tap memory.
					wr_addr <= init_q;
					if (init_q == A_MX || init_q == A_MY)
						wr_data <= W'(1) << (W - 1);
					else if (init_q == A_HX || init_q == A_SX || init_q == A_SY)
						wr_data <= W'(1) << FRAC;
					else
						wr_data <= '0;
					init_q <= init_q + 1'b1;
					if (init_q == A_END - 1)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_acc) begin
						x_q     <= W'(sample) << MFRAC;
						step_q  <= '0;
						state_q <= S_MEAN;
					end
				end
				S_MEAN: begin
					// step0: rd_s1 = prev x; step1: product, rd_s1 = prev mean.
					case (step_q)
						4'd0: begin
							step_q <= step_q + 1'b1;
							mul_a  <= PW'(MEAN_B0);
							mul_b  <= PW'({1'b0, x_q}) + PW'({1'b0, rd_s1});
							mul_sh <= 7'(COEF_FRAC);
							wr_addr <= A_MX; wr_data <= x_q;
						end
						4'd1: begin
							step_q <= step_q + 1'b1;
							acc_q  <= mul_res;
							mul_a  <= PW'(MEAN_NA1);
							mul_b  <= PW'({1'b0, rd_s1});
						end
						4'd2: begin
							step_q <= step_q + 1'b1;
							acc_q <= acc_q + mul_res;
						end
						default: begin
							mean_q <= (acc_q > $signed((PW'(1) << W) - 1)) ? '1 : W'(acc_q);
							wr_addr <= A_MY;
							wr_data <= (acc_q > $signed((PW'(1) << W) - 1)) ? '1 : W'(acc_q);
							quo_q  <= '0;
							rem_q  <= '0;
							t0_q   <= x_q;
							dcnt_q <= '0;
							state_q <= S_DIV;
						end
					endcase
				end
				S_DIV: begin
					// Restoring division, one quotient bit a cycle, of x*2^FRAC by mean.
					// A one leaving the top of the quotient register means the ratio
					// is 256 or more.
					if (dcnt_q < DCW'(W + FRAC)) begin
						logic [W+1:0] r2;
						r2 = {rem_q[W:0], (dcnt_q < DCW'(W)) ? t0_q[W-1] : 1'b0};
						if (dcnt_q < DCW'(W)) t0_q <= t0_q << 1;
						if (r2 >= {2'b00, mean_q}) begin
							rem_q <= r2 - {2'b00, mean_q};
							quo_q <= {quo_q[QB-2:0], 1'b1};
						end else begin
							rem_q <= r2;
							quo_q <= {quo_q[QB-2:0], 1'b0};
						end
						if (dcnt_q == '0) sat_q <= 1'b0;
						else if (quo_q[QB-1]) sat_q <= 1'b1;
						dcnt_q <= dcnt_q + 1'b1;
					end else begin
						if (mean_q == '0 || sat_q || quo_q[QB-1])
							y_q <= {1'b0, {(W-1){1'b1}}};
						else
							y_q <= W'(quo_q);
						step_q <= '0;
						state_q <= S_HP;
					end
				end
				S_HP: begin
					// rd_s1 = prev e on step0, prev y on step1.
					case (step_q)
						4'd0: begin
							step_q <= step_q + 1'b1;
							mul_a <= PW'(HP_B0); mul_b <= sx(y_q) - sx(rd_s1);
							mul_sh <= 7'(COEF_FRAC);
							wr_addr <= A_HX; wr_data <= y_q;
						end
						4'd1: begin
							step_q <= step_q + 1'b1;
							acc_q <= mul_res; mul_a <= PW'(HP_NA1); mul_b <= sx(rd_s1);
						end
						default: begin
							y_q <= sat_w(acc_q + mul_res);
							wr_addr <= A_HY;
							wr_data <= sat_w(acc_q + mul_res);
							sec_q <= '0; step_q <= '0;
							state_q <= S_BQ;
						end
					endcase
				end
				S_BQ: begin
					// Reads x1,x2,y1,y2 on steps 0..3 (data on 1..4); five products.
					case (step_q)
						4'd0: begin
							step_q <= step_q + 1'b1;
							mul_a <= PW'(bq_coef(sec_q, 3'd0)); mul_b <= sx(y_q);
							mul_sh <= 7'(COEF_FRAC);
						end
						4'd1: begin
							step_q <= step_q + 1'b1;
							acc_q <= mul_res; t0_q <= rd_s1;
							mul_a <= PW'(bq_coef(sec_q, 3'd1)); mul_b <= sx(rd_s1);
						end
						4'd2: begin
							step_q <= step_q + 1'b1;
							acc_q <= acc_q + mul_res;
							mul_a <= PW'(bq_coef(sec_q, 3'd2)); mul_b <= sx(rd_s1);
						end
						4'd3: begin
							step_q <= step_q + 1'b1;
							acc_q <= acc_q + mul_res; t2_q <= rd_s1;
							mul_a <= PW'(bq_coef(sec_q, 3'd3)); mul_b <= sx(rd_s1);
						end
						4'd4: begin
							step_q <= step_q + 1'b1;
							acc_q <= acc_q + mul_res;
							mul_a <= PW'(bq_coef(sec_q, 3'd4)); mul_b <= -sx(rd_s1);
						end
						4'd5: begin
							step_q <= step_q + 1'b1;
							acc_q <= acc_q + mul_res;
							wr_addr <= A_BQ + AW'({sec_q, 2'b00}) + AW'(1);
							wr_data <= t0_q;
						end
						4'd6: begin
							step_q <= step_q + 1'b1;
							wr_addr <= A_BQ + AW'({sec_q, 2'b00});
							wr_data <= y_q;
						end
						4'd7: begin
							step_q <= step_q + 1'b1;
							wr_addr <= A_BQ + AW'({sec_q, 2'b00}) + AW'(3);
							wr_data <= t2_q;
						end
						default: begin
							wr_addr <= A_BQ + AW'({sec_q, 2'b00}) + AW'(2);
							wr_data <= sat_w(acc_q);
							y_q <= sat_w(acc_q);
							step_q <= '0;
							if (sec_q == 3'd4) state_q <= S_SQ;
							else sec_q <= sec_q + 1'b1;
						end
					endcase
				end
				S_SQ: begin
					if (step_q == 4'd0) begin
						step_q <= step_q + 1'b1;
						mul_a <= sx(y_q); mul_b <= sx(y_q); mul_sh <= 7'(FRAC);
					end else begin
						// Square clipped to the positive word range.
						if (mul_res > $signed((PW'(1) << (W - 1)) - 1))
							y_q <= {1'b0, {(W-1){1'b1}}};
						else
							y_q <= W'(mul_res);
						step_q <= '0;
						state_q <= S_SM;
					end
				end
				S_SM: begin
					// rd_s1 = prev sq on step0, prev sm on step1.
					case (step_q)
						4'd0: begin
							step_q <= step_q + 1'b1;
							mul_a <= PW'(SM_B0); mul_b <= sx(y_q) + sx(rd_s1);
							mul_sh <= 7'(COEF_FRAC);
							wr_addr <= A_SX; wr_data <= y_q;
						end
						4'd1: begin
							step_q <= step_q + 1'b1;
							acc_q <= mul_res; mul_a <= PW'(SM_NA1); mul_b <= sx(rd_s1);
						end
						default: begin
							y_q <= sat_w(acc_q + mul_res);
							wr_addr <= A_SY;
							wr_data <= sat_w(acc_q + mul_res);
							step_q <= '0;
							if (seen_q < warm_q) begin
								seen_q <= seen_q + 1'b1;
								state_q <= S_WB;
							end else begin
								state_q <= S_SCALE;
							end
						end
					endcase
				end
				S_SCALE: begin
					if (step_q == 4'd0) begin
						step_q <= step_q + 1'b1;
						mul_a <= sx(y_q); mul_b <= PW'({1'b0, SCALE_Q16});
						mul_sh <= 7'(FRAC);
					end else begin
						if (y_q[W-1] || y_q == '0) begin
							sensation <= '0; saturated <= 1'b0;
						end else if (mul_res > $signed(PW'(32'hFFFF_FFFF))) begin
							sensation <= '1; saturated <= 1'b1;
						end else begin
							sensation <= SENS_BITS'(mul_res); saturated <= 1'b0;
						end
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_stall) state_q <= S_IDLE;
				end
				S_WB: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_one_hot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state register lost its one-hot code");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("sample taken while a result is pending");
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sensation) && $stable(saturated))
		else $error("stalled result changed");
	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> sensation == '1)
		else $error("saturated flag without clipped value");

endmodule
